@@ hw/rtl/frmg_pkg.sv @@
// frmg_pkg: shared constants and control types for the frame rotate/mirror/gray block.
// Used by frmg_ctrl, frmg_dp and frame_rotate_mirror_gray; no dependencies.
package frmg_pkg;

   localparam int MAX_DIM_DEF = 128;

   // register indexes on the CSR channel
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd2;

   localparam logic [7:0] DIM_RESET = 8'd128;

   // transform modes; codes 5..7 behave as copy
   localparam logic [2:0] MODE_COPY  = 3'd0;
   localparam logic [2:0] MODE_CW    = 3'd1;
   localparam logic [2:0] MODE_CCW   = 3'd2;
   localparam logic [2:0] MODE_VFLIP = 3'd3;
   localparam logic [2:0] MODE_HFLIP = 3'd4;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   // gray weights 0.3 / 0.59 / 0.11 in unsigned Q0.16
   localparam logic [15:0] GRAY_KR = 16'd19661;
   localparam logic [15:0] GRAY_KG = 16'd38666;
   localparam logic [15:0] GRAY_KB = 16'd7209;

   typedef struct packed {
      logic capture;   // latch request payload
      logic do_load;   // write pixel, step load counters
      logic do_emit;   // read store, step emit counters
      logic do_mul;    // register gray products
      logic do_sum;    // register gray sum
   } dp_cmd_type;

   typedef struct packed {
      logic cmd_emit;
      logic frame_full;
   } dp_status_type;

endpackage

@@ hw/rtl/frmg_if.sv @@
// Channel interfaces for frame_rotate_mirror_gray: request, response and CSR write.
// Depends on nothing; field widths are fixed.
interface frmg_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;
   modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

interface frmg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_gray;
   logic       last_pixel;
   modport source (output valid, out_red, out_green, out_blue, out_gray, last_pixel,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_gray, last_pixel,
                   output ready);
endinterface

interface frmg_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/frmg_ctrl.sv @@
// frmg_ctrl: sequencer for one request at a time; drives datapath commands.
// Depends on frmg_pkg.
module frmg_ctrl
   import frmg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_CHECK = 6'b000100,
      ST_MUL   = 6'b001000,
      ST_SUM   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.capture = req_valid && (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // captured command decides; emit before a full frame is dropped
            if (!status.cmd_emit) begin
               state_in = ST_LOAD;
            end else if (status.frame_full) begin
               cmd.do_emit = 1'b1;
               state_in    = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.do_load = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.do_sum = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ hw/rtl/frmg_dp.sv @@
// frmg_dp: CSRs, load/emit counters, frame store and gray arithmetic.
// Depends on frmg_pkg; driven by frmg_ctrl commands.
module frmg_dp
   import frmg_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data,
   input  logic                 req_cmd,
   input  logic [7:0]           req_red,
   input  logic [7:0]           req_green,
   input  logic [7:0]           req_blue,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   output logic [7:0]           rsp_red,
   output logic [7:0]           rsp_green,
   output logic [7:0]           rsp_blue,
   output logic [7:0]           rsp_gray,
   output logic                 rsp_last
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int AW    = 2 * IW;
   localparam logic [DIM_W-1:0] ONE = DIM_W'(1);

   // configuration
   logic [7:0] width_ff, height_ff;
   logic [2:0] mode_ff;

   // captured request
   logic        cmd_ff;
   logic [23:0] pix_ff;

   // counters
   logic [DIM_W-1:0] load_row_ff, load_col_ff, emit_row_ff, emit_col_ff;

   // frame store and read pipeline
   logic [23:0] store_mem [2**AW];
   logic [23:0] rd_data_ff;
   logic        last_ff;
   logic [23:0] prod_r_ff, prod_g_ff, prod_b_ff;
   logic [7:0]  gray_ff;

   logic [DIM_W-1:0] w_eff, h_eff, out_w, out_h;
   logic             rot;

   always_comb begin
      if (width_ff == 8'd0)                 w_eff = ONE;
      else if (32'(width_ff) > MAX_DIM)     w_eff = DIM_W'(MAX_DIM);
      else                                  w_eff = DIM_W'(width_ff);
      if (height_ff == 8'd0)                h_eff = ONE;
      else if (32'(height_ff) > MAX_DIM)    h_eff = DIM_W'(MAX_DIM);
      else                                  h_eff = DIM_W'(height_ff);
      rot   = (mode_ff == MODE_CW) || (mode_ff == MODE_CCW);
      out_w = rot ? h_eff : w_eff;
      out_h = rot ? w_eff : h_eff;
   end

   // load path
   logic [DIM_W-1:0] lr_a, lc_a, lr_b, lc_b, lr_c, lc_c, lc_n;
   logic             new_frame;
   logic [AW-1:0]    wr_addr;

   always_comb begin
      if (load_col_ff >= w_eff) begin
         lc_a = '0;
         lr_a = load_row_ff + ONE;
      end else begin
         lc_a = load_col_ff;
         lr_a = load_row_ff;
      end
      new_frame = (lr_a >= h_eff);
      lr_b = new_frame ? '0 : lr_a;
      lc_b = new_frame ? '0 : lc_a;
      lc_n = lc_b + ONE;
      if (lc_n >= w_eff) begin
         lc_c = '0;
         lr_c = lr_b + ONE;
      end else begin
         lc_c = lc_n;
         lr_c = lr_b;
      end
      wr_addr = {lr_b[IW-1:0], lc_b[IW-1:0]};
   end

   // emit path
   logic [DIM_W-1:0] er_a1, er_a, ec_a, src_row, src_col, ec_n, er_n, er_p;
   logic             last_c;
   logic [AW-1:0]    rd_addr;

   always_comb begin
      if (emit_col_ff >= out_w) begin
         ec_a  = '0;
         er_a1 = emit_row_ff + ONE;
      end else begin
         ec_a  = emit_col_ff;
         er_a1 = emit_row_ff;
      end
      er_a = (er_a1 >= out_h) ? '0 : er_a1;
      case (mode_ff)
         MODE_CW: begin
            src_row = h_eff - ONE - ec_a;
            src_col = er_a;
         end
         MODE_CCW: begin
            src_row = ec_a;
            src_col = w_eff - ONE - er_a;
         end
         MODE_VFLIP: begin
            src_row = h_eff - ONE - er_a;
            src_col = ec_a;
         end
         MODE_HFLIP: begin
            src_row = er_a;
            src_col = w_eff - ONE - ec_a;
         end
         default: begin
            src_row = er_a;
            src_col = ec_a;
         end
      endcase
      rd_addr = {src_row[IW-1:0], src_col[IW-1:0]};
      last_c  = (er_a == out_h - ONE) && (ec_a == out_w - ONE);
      ec_n    = ec_a + ONE;
      er_p    = er_a + ONE;
      if (ec_n >= out_w) begin
         ec_n = '0;
         er_n = (er_p >= out_h) ? '0 : er_p;
      end else begin
         er_n = er_a;
      end
   end

   assign status.cmd_emit   = (cmd_ff == CMD_EMIT);
   assign status.frame_full = (load_row_ff >= h_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= DIM_RESET;
         height_ff   <= DIM_RESET;
         mode_ff     <= MODE_COPY;
         load_row_ff <= '0;
         load_col_ff <= '0;
         emit_row_ff <= '0;
         emit_col_ff <= '0;
      end else begin
         if (csr_wr) begin
            case (csr_index)
               CSR_WIDTH:  width_ff  <= csr_data;
               CSR_HEIGHT: height_ff <= csr_data;
               CSR_MODE:   mode_ff   <= csr_data[2:0];
               default:    ;
            endcase
         end
         if (cmd.do_load) begin
            load_row_ff <= lr_c;
            load_col_ff <= lc_c;
            if (new_frame) begin
               emit_row_ff <= '0;
               emit_col_ff <= '0;
            end
         end
         if (cmd.do_emit) begin
            emit_row_ff <= er_n;
            emit_col_ff <= ec_n;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         pix_ff <= {req_red, req_green, req_blue};
      end
      if (cmd.do_load) store_mem[wr_addr] <= pix_ff;
      if (cmd.do_emit) begin
         rd_data_ff <= store_mem[rd_addr];
         last_ff    <= last_c;
      end
      if (cmd.do_mul) begin
         prod_r_ff <= 24'(GRAY_KR) * 24'(rd_data_ff[23:16]);
         prod_g_ff <= 24'(GRAY_KG) * 24'(rd_data_ff[15:8]);
         prod_b_ff <= 24'(GRAY_KB) * 24'(rd_data_ff[7:0]);
      end
      // weights sum to 1.0, so the total stays below 2^24
      if (cmd.do_sum) gray_ff <= 8'((prod_r_ff + prod_g_ff + prod_b_ff) >> 16);
   end

   assign rsp_red   = rd_data_ff[23:16];
   assign rsp_green = rd_data_ff[15:8];
   assign rsp_blue  = rd_data_ff[7:0];
   assign rsp_gray  = gray_ff;
   assign rsp_last  = last_ff;

endmodule

@@ hw/rtl/frame_rotate_mirror_gray.sv @@
// frame_rotate_mirror_gray: frame buffer that rotates/flips a stored RGB frame
// and adds gray. Depends on frmg_pkg, frmg_if, frmg_ctrl and frmg_dp.
//
// Usage:
//   req_chan  : one command per transfer. cmd=0 loads the next raster pixel
//               (in_red/in_green/in_blue); cmd=1 asks for the next output pixel.
//   rsp_chan  : one transfer per served emit: RGB, gray and last_pixel on the
//               final pixel of the output frame. Loads, and emits before the
//               frame is full, give no response.
//   csr_chan  : index 0 width, 1 height, 2 transform mode; always ready. Write
//               only while the block is idle.
// Timing: the sequencer handles one command at a time. A load passes through
//   the check and load states before req ready returns; an emit passes the
//   store read, product stage and sum stage before rsp valid, then waits for
//   rsp ready, and req ready returns the cycle after the rsp transfer.
//   An emit that is dropped passes only the check state before req ready returns.
// Reset clears counters, state and config registers (128 x 128, copy); the frame store
//   holds garbage until loaded. While the receiver stalls, the response holds
//   and no new command is taken.
module frame_rotate_mirror_gray
   import frmg_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic      clock,
   input  logic      reset,
   frmg_req_if.sink  req_chan,
   frmg_rsp_if.source rsp_chan,
   frmg_csr_if.sink  csr_chan
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          req_ready_w;
   logic          rsp_valid_w;

   assign req_chan.ready = req_ready_w;
   assign rsp_chan.valid = rsp_valid_w;
   assign csr_chan.ready = 1'b1;

   frmg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready_w),
      .rsp_valid (rsp_valid_w),
      .rsp_ready (rsp_chan.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   frmg_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .req_cmd   (req_chan.cmd),
      .req_red   (req_chan.in_red),
      .req_green (req_chan.in_green),
      .req_blue  (req_chan.in_blue),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .rsp_red   (rsp_chan.out_red),
      .rsp_green (rsp_chan.out_green),
      .rsp_blue  (rsp_chan.out_blue),
      .rsp_gray  (rsp_chan.out_gray),
      .rsp_last  (rsp_chan.last_pixel)
   );

endmodule
